// File: rtl/t3pps_pkg.sv
// ---------------------------------------------------------------------------
// T3 photon pixel sorter package
// Shared constants, codes, the per-record tracking word and a small helper.
// ---------------------------------------------------------------------------
`default_nettype none

package t3pps_pkg;

  // Fixed widths of the record fields and of absolute time.
  localparam int TIME_BITS = 48;
  localparam int DIM_W     = 16;
  localparam int ROW_W     = 13;
  localparam int FRAME_W   = 16;
  localparam int BIN_W     = 12;
  localparam int COL_W     = 16;
  localparam int RATE_W    = 32;
  localparam int SYNC_W    = 16;
  localparam int CODE_W    = 4;
  localparam int DELTA_W   = 40;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 48;

  // Defaults for the top level parameters.
  localparam int WRAP_PERIOD_DEF = 65536;
  localparam int MAX_DIM_DEF     = 4096;

  // Special record channel and marker codes.
  localparam logic [CODE_W-1:0] SPECIAL_CHANNEL = 4'hF;
  localparam logic [CODE_W-1:0] MAX_CHANNEL     = 4'd4;
  localparam logic [CODE_W-1:0] MK_OVERFLOW     = 4'd0;
  localparam logic [CODE_W-1:0] MK_LINE_END     = 4'd1;
  localparam logic [CODE_W-1:0] MK_LINE_START   = 4'd2;
  localparam logic [CODE_W-1:0] MK_FRAME_START  = 4'd4;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_SPECIAL       = 3'd0,
    ST_ACCEPTED      = 3'd1,
    ST_OUTSIDE_LINE  = 3'd2,
    ST_OUTSIDE_IMAGE = 3'd3,
    ST_OUTSIDE_GATE  = 3'd4,
    ST_STOPPED       = 3'd5
  } status_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_PIXEL_RATE   = 3'd2,
    REG_STOP_TIME    = 3'd3,
    REG_GATE_START   = 3'd4,
    REG_GATE_STOP    = 3'd5
  } cfg_reg_t;

  // Reset values of the configuration registers.
  localparam logic [ROW_W-1:0]     IMAGE_WIDTH_RST  = 13'd256;
  localparam logic [ROW_W-1:0]     IMAGE_HEIGHT_RST = 13'd256;
  localparam logic [RATE_W-1:0]    PIXEL_RATE_RST   = 32'h0100_0000;
  localparam logic [TIME_BITS-1:0] STOP_TIME_RST    = 48'hFFFF_FFFF_FFFF;
  localparam logic [BIN_W-1:0]     GATE_START_RST   = 12'd0;
  localparam logic [BIN_W-1:0]     GATE_STOP_RST    = 12'hFFF;

  // Record as it leaves the tracker. A kind of ST_ACCEPTED means the photon
  // lies inside a line and still needs its column and final class.
  typedef struct packed {
    status_t               kind;
    logic                  bad;
    logic [ROW_W-1:0]      row;
    logic [FRAME_W-1:0]    frame;
    logic [BIN_W-1:0]      bin;
    logic [TIME_BITS-1:0]  t;
    logic                  row_oob;
  } rec_t;

  // Clamp an image dimension into [lo, hi].
  function automatic logic [DIM_W-1:0] eff_dim(logic [ROW_W-1:0] v,
                                                logic [DIM_W-1:0] lo,
                                                logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] vx;
    vx = DIM_W'(v);
    if (vx < lo) begin
      return lo;
    end else if (vx > hi) begin
      return hi;
    end
    return vx;
  endfunction

endpackage

`default_nettype wire

// File: rtl/t3pps_track.sv
// ---------------------------------------------------------------------------
// T3 photon pixel sorter record tracker
// Holds the line and frame state, unwraps sync counts into absolute time and
// tags each record; updates state once per stepped record.
// ---------------------------------------------------------------------------
`default_nettype none

module t3pps_track #(
  parameter int WRAP_PERIOD = t3pps_pkg::WRAP_PERIOD_DEF,
  parameter int MAX_DIM     = t3pps_pkg::MAX_DIM_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             step_en,
  input  wire logic [t3pps_pkg::CODE_W-1:0]     channel,
  input  wire logic [t3pps_pkg::CODE_W-1:0]     marker_bits,
  input  wire logic [t3pps_pkg::SYNC_W-1:0]     sync_count,
  input  wire logic [t3pps_pkg::BIN_W-1:0]      micro_time,
  input  wire logic [t3pps_pkg::ROW_W-1:0]      image_height,
  input  wire logic [t3pps_pkg::TIME_BITS-1:0]  stop_time,
  output t3pps_pkg::rec_t                       rec,
  output logic [t3pps_pkg::TIME_BITS-1:0]       line_start
);
  import t3pps_pkg::*;

  localparam logic [TIME_BITS-1:0] WRAP_C    = TIME_BITS'(WRAP_PERIOD);
  localparam logic [DIM_W-1:0]     MAX_DIM_C = DIM_W'(MAX_DIM);

  logic [TIME_BITS-1:0] ovf_r, ovf_nxt;
  logic [TIME_BITS-1:0] ls_r, ls_nxt;
  logic [TIME_BITS-1:0] last_r, last_nxt;
  logic [ROW_W-1:0]     row_r, row_nxt;
  logic [FRAME_W-1:0]   frame_r, frame_nxt;
  logic                 bl_r, bl_nxt;
  logic                 bf_r, bf_nxt;

  logic [TIME_BITS-1:0] t;
  logic [DIM_W-1:0]     eff_h;
  logic [ROW_W-1:0]     row_inc;
  logic                 stopped;

  assign t          = ovf_r + TIME_BITS'(sync_count);
  assign eff_h      = eff_dim(image_height, DIM_W'(1), MAX_DIM_C);
  assign row_inc    = row_r + ROW_W'(1);
  assign stopped    = (last_r >= stop_time);
  assign line_start = ls_r;

  // Next state and record tag.
  always_comb begin
    ovf_nxt   = ovf_r;
    ls_nxt    = ls_r;
    last_nxt  = last_r;
    row_nxt   = row_r;
    frame_nxt = frame_r;
    bl_nxt    = bl_r;
    bf_nxt    = bf_r;
    rec       = '0;
    if (stopped) begin
      rec.kind = ST_STOPPED;
    end else if (channel == SPECIAL_CHANNEL) begin
      if (marker_bits == MK_LINE_START) begin
        if (!bf_r) begin
          last_nxt = t;
          ls_nxt   = t;
          bl_nxt   = 1'b0;
        end
      end else if (marker_bits == MK_LINE_END) begin
        if (!bf_r && !bl_r) begin
          bl_nxt = 1'b1;
          if (DIM_W'(row_inc) >= eff_h) begin
            bf_nxt  = 1'b1;
            row_nxt = '0;
          end else begin
            row_nxt = row_inc;
          end
        end
      end else if (marker_bits == MK_FRAME_START) begin
        last_nxt  = t;
        bf_nxt    = 1'b0;
        frame_nxt = frame_r + FRAME_W'(1);
      end else if (marker_bits == MK_OVERFLOW) begin
        ovf_nxt = ovf_r + WRAP_C;
      end
      rec.kind  = ST_SPECIAL;
      rec.row   = row_nxt;
      rec.frame = frame_nxt;
      rec.t     = t;
    end else begin
      last_nxt    = t;
      rec.kind    = (bl_r || bf_r) ? ST_OUTSIDE_LINE : ST_ACCEPTED;
      rec.bad     = (channel == '0) || (channel > MAX_CHANNEL);
      rec.row     = row_r;
      rec.frame   = frame_r;
      rec.bin     = micro_time;
      rec.t       = t;
      rec.row_oob = (DIM_W'(row_r) >= eff_h);
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_r   <= '0;
      ls_r    <= '0;
      last_r  <= '0;
      row_r   <= '0;
      frame_r <= '0;
      bl_r    <= 1'b1;
      bf_r    <= 1'b1;
    end else if (step_en) begin
      ovf_r   <= ovf_nxt;
      ls_r    <= ls_nxt;
      last_r  <= last_nxt;
      row_r   <= row_nxt;
      frame_r <= frame_nxt;
      bl_r    <= bl_nxt;
      bf_r    <= bf_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/t3_photon_pixel_sorter.sv
// ---------------------------------------------------------------------------
// T3 photon pixel sorter
// Sorts decoded T3 time-tag records into image lines and frames, computes a
// pixel column per photon and classifies it against image and time gate.
// ---------------------------------------------------------------------------
//
//  Channel  Dir  Handshake              Carries
//  in_      in   in_tvalid/in_tready    one T3 record request
//  out_     out  out_tvalid/out_tready  one classified result per record
//  cfg_     in   cfg_valid/cfg_ready    register index and write data
//
// One record is accepted per cycle while in_tready is high; its result is
// offered once the request has passed the input register and one stage each
// for the tracker, the time difference, the two 40x16 column multiplies and
// the classification into the output register.
// Each pipeline stage moves on when the stage after it is empty or moving,
// so bubbles close up; while a result waits, requests are still accepted
// until all five stages hold a record, and then in_tready drops.
// Reset is synchronous and active low; it clears all stage valid bits, resets
// the line and frame state and loads the configuration registers' reset values.
//
`default_nettype none

module t3_photon_pixel_sorter #(
  parameter int WRAP_PERIOD = t3pps_pkg::WRAP_PERIOD_DEF,
  parameter int MAX_DIM     = t3pps_pkg::MAX_DIM_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // channel[3:0], marker_bits[7:4], sync_count[23:8], micro_time[35:24]
  input  wire logic [39:0]                       in_tdata,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // pixel_column[15:0], pixel_row[28:16], frame_index[44:29],
  // photon_bin[56:45], abs_time[104:57]
  output logic [111:0]                           out_tdata,
  // status[2:0], bad_channel[3]
  output logic [3:0]                             out_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [t3pps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [t3pps_pkg::CFG_DAT_W-1:0]   cfg_data
);
  import t3pps_pkg::*;

  localparam logic [DIM_W-1:0] MAX_DIM_C = DIM_W'(MAX_DIM);

  // Configuration registers.
  logic [ROW_W-1:0]     image_width_r, image_height_r;
  logic [RATE_W-1:0]    pixel_rate_r;
  logic [TIME_BITS-1:0] stop_time_r;
  logic [BIN_W-1:0]     gate_start_r, gate_stop_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= IMAGE_WIDTH_RST;
      image_height_r <= IMAGE_HEIGHT_RST;
      pixel_rate_r   <= PIXEL_RATE_RST;
      stop_time_r    <= STOP_TIME_RST;
      gate_start_r   <= GATE_START_RST;
      gate_stop_r    <= GATE_STOP_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_data[ROW_W-1:0];
        REG_IMAGE_HEIGHT: image_height_r <= cfg_data[ROW_W-1:0];
        REG_PIXEL_RATE:   pixel_rate_r   <= cfg_data[RATE_W-1:0];
        REG_STOP_TIME:    stop_time_r    <= cfg_data[TIME_BITS-1:0];
        REG_GATE_START:   gate_start_r   <= cfg_data[BIN_W-1:0];
        REG_GATE_STOP:    gate_stop_r    <= cfg_data[BIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage valid bits and the ready chain from the output backwards.
  logic va_r, vb_r, vc_r, vd_r, out_valid_r;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;

  assign rdy_e     = !out_valid_r || out_tready;
  assign rdy_d     = !vd_r || rdy_e;
  assign rdy_c     = !vc_r || rdy_d;
  assign rdy_b     = !vb_r || rdy_c;
  assign rdy_a     = !va_r || rdy_b;
  assign in_tready = rdy_a;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      vc_r        <= 1'b0;
      vd_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= in_tvalid;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vc_r <= vb_r;
      if (rdy_d) vd_r <= vc_r;
      if (rdy_e) out_valid_r <= vd_r;
    end
  end

  // Stage A: input register.
  logic [CODE_W-1:0] ch_a_r, mk_a_r;
  logic [SYNC_W-1:0] sc_a_r;
  logic [BIN_W-1:0]  mt_a_r;

  always_ff @(posedge clk) begin
    if (rdy_a && in_tvalid) begin
      ch_a_r <= in_tdata[3:0];
      mk_a_r <= in_tdata[7:4];
      sc_a_r <= in_tdata[23:8];
      mt_a_r <= in_tdata[35:24];
    end
  end

  // Stage B: line and frame tracking, one state update per record.
  rec_t                 rec_b_nxt, rec_b_r;
  logic [TIME_BITS-1:0] ls_b_nxt, ls_b_r;
  logic                 step_b;

  assign step_b = va_r && rdy_b;

  t3pps_track #(
    .WRAP_PERIOD (WRAP_PERIOD),
    .MAX_DIM     (MAX_DIM)
  ) u_track (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (step_b),
    .channel      (ch_a_r),
    .marker_bits  (mk_a_r),
    .sync_count   (sc_a_r),
    .micro_time   (mt_a_r),
    .image_height (image_height_r),
    .stop_time    (stop_time_r),
    .rec          (rec_b_nxt),
    .line_start   (ls_b_nxt)
  );

  always_ff @(posedge clk) begin
    if (step_b) begin
      rec_b_r <= rec_b_nxt;
      ls_b_r  <= ls_b_nxt;
    end
  end

  // Stage C: time since line start, clipped at zero.
  rec_t                 rec_c_r;
  logic [DELTA_W-1:0]   delta_c_r;
  logic                 big_c_r;
  logic [TIME_BITS-1:0] delta_full;

  assign delta_full = (rec_b_r.t >= ls_b_r) ? (rec_b_r.t - ls_b_r) : '0;

  always_ff @(posedge clk) begin
    if (vb_r && rdy_c) begin
      rec_c_r   <= rec_b_r;
      delta_c_r <= delta_full[DELTA_W-1:0];
      big_c_r   <= |delta_full[TIME_BITS-1:DELTA_W];
    end
  end

  // Stage D: the rate multiply, split into upper and lower 16-bit halves.
  localparam int PROD_W = DELTA_W + 16;

  rec_t              rec_d_r;
  logic [PROD_W-1:0] phi_d_r, plo_d_r;
  logic              big_d_r;

  always_ff @(posedge clk) begin
    if (vc_r && rdy_d) begin
      rec_d_r <= rec_c_r;
      phi_d_r <= PROD_W'(delta_c_r) * PROD_W'(pixel_rate_r[RATE_W-1:16]);
      plo_d_r <= PROD_W'(delta_c_r) * PROD_W'(pixel_rate_r[15:0]);
      big_d_r <= big_c_r;
    end
  end

  // Stage E: round the column, saturate and classify.
  localparam int TOT_W = PROD_W + 1;

  logic [TOT_W-1:0] total;
  logic [COL_W-1:0] col_raw, col_e;
  logic [DIM_W-1:0] eff_w;
  logic             sat, in_gate;
  status_t          status_e;

  assign total   = TOT_W'({phi_d_r[23:0], 16'b0}) + TOT_W'(plo_d_r)
                 + (TOT_W'(1) << 23);
  assign sat     = (pixel_rate_r != '0)
                 && (big_d_r || (|phi_d_r[PROD_W-1:24]) || (|total[TOT_W-1:40]));
  assign col_raw = sat ? '1 : total[39:24];
  assign eff_w   = eff_dim(image_width_r, '0, MAX_DIM_C);
  assign in_gate = (rec_d_r.bin >= gate_start_r) && (rec_d_r.bin <= gate_stop_r);

  always_comb begin
    col_e    = '0;
    status_e = rec_d_r.kind;
    if (rec_d_r.kind == ST_ACCEPTED) begin
      col_e = col_raw;
      if ((DIM_W'(col_raw) >= eff_w) || rec_d_r.row_oob) begin
        status_e = ST_OUTSIDE_IMAGE;
      end else if (in_gate) begin
        status_e = ST_ACCEPTED;
      end else begin
        status_e = ST_OUTSIDE_GATE;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (vd_r && rdy_e) begin
      out_tdata <= {7'b0, rec_d_r.t, rec_d_r.bin, rec_d_r.frame, rec_d_r.row, col_e};
      out_tuser <= {rec_d_r.bad, status_e};
    end
  end

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// T3 photon pixel sorter testbench
// Streams T3 time-tag records into the sorter and checks every classified
// result against a cycle-free predictor of the line, frame and column logic.
// Directed records cover the markers, column extremes, rounding, the time
// gate and the stop time. Random scans of frames and lines with noise follow
// under several register settings, with random idling on both streams and
// one long output hold-off.
// ---------------------------------------------------------------------------

module tb;
  import t3pps_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 12;
  localparam int PRINT_CAP     = 100;
  localparam int MAX_GAP       = 19;
  // A marker code that the sorter does not act on.
  localparam logic [CODE_W-1:0] MK_UNUSED = 4'd7;

  // One expected result, field by field.
  typedef struct {
    status_t               status;
    logic                  bad;
    logic [COL_W-1:0]      col;
    logic [ROW_W-1:0]      row;
    logic [FRAME_W-1:0]    frame;
    logic [BIN_W-1:0]      bin;
    logic [TIME_BITS-1:0]  abs_t;
  } sorted_photon_t;

  logic                 clk;
  logic                 rst_n;
  logic [39:0]          in_tdata;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [111:0]         out_tdata;
  logic [3:0]           out_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  // Results still owed by the sorter, oldest first.
  sorted_photon_t pending_results[$];
  int mismatch_count = 0;
  int cycle_count    = 0;

  // Idling controls shared by the sender, the receiver and the tests.
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int rx_hold_cycles = 0;

  // Predictor copy of the registers.
  logic [ROW_W-1:0]     cfg_width;
  logic [ROW_W-1:0]     cfg_height;
  logic [RATE_W-1:0]    cfg_rate;
  logic [TIME_BITS-1:0] cfg_stop;
  logic [BIN_W-1:0]     cfg_gate_lo;
  logic [BIN_W-1:0]     cfg_gate_hi;

  // Predictor copy of the scan state.
  logic [TIME_BITS-1:0] ovf_time;
  logic [TIME_BITS-1:0] line_start;
  logic [TIME_BITS-1:0] last_t;
  logic [ROW_W-1:0]     row_cnt;
  logic [FRAME_W-1:0]   frame_cnt;
  logic                 in_line_gap;
  logic                 in_frame_gap;

  // Record generator state for the random scans.
  logic [SYNC_W-1:0] scan_sync = '0;
  int photons_left = 0;

  t3_photon_pixel_sorter i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle counter and run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("t3_photon_pixel_sorter test failed");
      $finish;
    end
  end

  // Rounded column of a time difference at a Q8.24 pixel rate, saturated.
  function automatic logic [COL_W-1:0] column_from_delta(logic [TIME_BITS-1:0] delta,
                                                         logic [RATE_W-1:0] rate);
    logic [95:0] prod;
    prod = {48'b0, delta} * {64'b0, rate} + (96'd1 << 23);
    if (prod[95:40] != '0) begin
      return '1;
    end
    return prod[39:24];
  endfunction

  // Applies one record to the predictor state and returns its result.
  function automatic sorted_photon_t classify_record(logic [CODE_W-1:0] ch,
                                                     logic [CODE_W-1:0] mk,
                                                     logic [SYNC_W-1:0] sc,
                                                     logic [BIN_W-1:0] mt);
    sorted_photon_t res;
    logic [TIME_BITS-1:0] t;
    logic [TIME_BITS-1:0] delta;
    logic [ROW_W-1:0] w_lim;
    logic [ROW_W-1:0] h_lim;
    res.status = ST_SPECIAL;
    res.bad    = 1'b0;
    res.col    = '0;
    res.row    = '0;
    res.frame  = '0;
    res.bin    = '0;
    res.abs_t  = '0;
    t = ovf_time + TIME_BITS'(sc);

    // Once the stop time is reached nothing moves and the result is blank.
    if (last_t >= cfg_stop) begin
      res.status = ST_STOPPED;
      return res;
    end

    // Image sizes beyond the largest act as the largest; height 0 acts as 1.
    w_lim = (cfg_width > MAX_DIM_DEF) ? ROW_W'(MAX_DIM_DEF) : cfg_width;
    if (cfg_height == '0) begin
      h_lim = ROW_W'(1);
    end else begin
      h_lim = (cfg_height > MAX_DIM_DEF) ? ROW_W'(MAX_DIM_DEF) : cfg_height;
    end

    if (ch == SPECIAL_CHANNEL) begin
      case (mk)
        MK_LINE_START: begin
          if (!in_frame_gap) begin
            last_t      = t;
            line_start  = t;
            in_line_gap = 1'b0;
          end
        end
        MK_LINE_END: begin
          if (!in_frame_gap && !in_line_gap) begin
            row_cnt     = row_cnt + ROW_W'(1);
            in_line_gap = 1'b1;
            if (row_cnt >= h_lim) begin
              in_frame_gap = 1'b1;
              row_cnt      = '0;
            end
          end
        end
        MK_FRAME_START: begin
          // A frame start mid frame keeps the row count and line flag.
          last_t       = t;
          in_frame_gap = 1'b0;
          frame_cnt    = frame_cnt + FRAME_W'(1);
        end
        MK_OVERFLOW: begin
          ovf_time = ovf_time + TIME_BITS'(WRAP_PERIOD_DEF);
        end
        default: begin
        end
      endcase
    end else begin
      res.bad = (ch == '0) || (ch > MAX_CHANNEL);
      res.bin = mt;
      last_t  = t;
      if (in_line_gap || in_frame_gap) begin
        res.status = ST_OUTSIDE_LINE;
      end else begin
        // A photon stamped before the line start sits in column 0.
        delta   = (t >= line_start) ? (t - line_start) : '0;
        res.col = column_from_delta(delta, cfg_rate);
        if (res.col >= w_lim || row_cnt >= h_lim) begin
          res.status = ST_OUTSIDE_IMAGE;
        end else if (mt >= cfg_gate_lo && mt <= cfg_gate_hi) begin
          res.status = ST_ACCEPTED;
        end else begin
          res.status = ST_OUTSIDE_GATE;
        end
      end
    end

    res.row   = row_cnt;
    res.frame = frame_cnt;
    res.abs_t = t;
    return res;
  endfunction

  // Prints one mismatch line (quiet after many) and counts it.
  task automatic report_mismatch(string what, logic [TIME_BITS-1:0] got,
                                 logic [TIME_BITS-1:0] want);
    if (mismatch_count < PRINT_CAP) begin
      $display("mismatch at cycle %0d: %s is 0x%0h, want 0x%0h",
               cycle_count, what, got, want);
    end
    mismatch_count++;
  endtask

  // Sends one record request and records what it should produce.
  task automatic send_record(logic [CODE_W-1:0] ch, logic [CODE_W-1:0] mk,
                             logic [SYNC_W-1:0] sc, logic [BIN_W-1:0] mt);
    int gap;
    gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {4'b0, mt, sc, mk, ch};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(classify_record(ch, mk, sc, mt));
  endtask

  // Stops sending and lets every owed result come out.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all registers while the sorter is idle.
  task automatic configure(logic [ROW_W-1:0] width, logic [ROW_W-1:0] height,
                           logic [RATE_W-1:0] rate, logic [TIME_BITS-1:0] stop,
                           logic [BIN_W-1:0] gate_lo, logic [BIN_W-1:0] gate_hi);
    int i;
    cfg_reg_t sel;
    logic [CFG_DAT_W-1:0] value;
    wait_idle();
    for (i = 0; i <= int'(REG_GATE_STOP); i++) begin
      sel = cfg_reg_t'(i);
      case (sel)
        REG_IMAGE_WIDTH:  value = CFG_DAT_W'(width);
        REG_IMAGE_HEIGHT: value = CFG_DAT_W'(height);
        REG_PIXEL_RATE:   value = CFG_DAT_W'(rate);
        REG_STOP_TIME:    value = CFG_DAT_W'(stop);
        REG_GATE_START:   value = CFG_DAT_W'(gate_lo);
        default:          value = CFG_DAT_W'(gate_hi);
      endcase
      cfg_index <= sel;
      cfg_data  <= value;
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid   <= 1'b0;
    cfg_width   = width;
    cfg_height  = height;
    cfg_rate    = rate;
    cfg_stop    = stop;
    cfg_gate_lo = gate_lo;
    cfg_gate_hi = gate_hi;
  endtask

  // Moves the scan's sync count on, reporting a wrap with an overflow marker.
  task automatic advance_scan_time(int step_max);
    int next_sync;
    next_sync = int'(scan_sync) + int'($urandom_range(0, step_max));
    if (next_sync >= WRAP_PERIOD_DEF) begin
      send_record(SPECIAL_CHANNEL, MK_OVERFLOW, SYNC_W'($urandom), BIN_W'($urandom));
      next_sync -= WRAP_PERIOD_DEF;
    end
    scan_sync = SYNC_W'(next_sync);
  endtask

  // Well-formed frames and lines with random photons, mixed with noise.
  task automatic scan_records(int count, int step_max, bit vary_idle);
    int n;
    logic [CODE_W-1:0] ch;
    for (n = 0; n < count; n++) begin
      if (vary_idle && n % 50 == 0) begin
        tx_idle = ($urandom_range(0, 2) != 0);
        rx_idle = ($urandom_range(0, 2) != 0);
      end
      if ($urandom_range(0, 99) < 12) begin
        // Noise: any record, unused marker codes and stray markers included.
        send_record(CODE_W'($urandom), CODE_W'($urandom), SYNC_W'($urandom),
                    BIN_W'($urandom));
      end else begin
        advance_scan_time(step_max);
        if (in_frame_gap) begin
          send_record(SPECIAL_CHANNEL, MK_FRAME_START, scan_sync, BIN_W'($urandom));
        end else if (in_line_gap) begin
          send_record(SPECIAL_CHANNEL, MK_LINE_START, scan_sync, BIN_W'($urandom));
          photons_left = $urandom_range(0, 24);
        end else if (photons_left == 0) begin
          send_record(SPECIAL_CHANNEL, MK_LINE_END, scan_sync, BIN_W'($urandom));
        end else begin
          // Mostly valid detector channels, now and then a bad one.
          if ($urandom_range(0, 6) != 0) begin
            ch = CODE_W'($urandom_range(1, 4));
          end else begin
            ch = CODE_W'($urandom_range(0, 14));
          end
          send_record(ch, CODE_W'($urandom), scan_sync, BIN_W'($urandom));
          photons_left--;
        end
      end
    end
  endtask

  // Reset values: markers in and out of frames, image edge, overflow.
  task automatic test_reset_defaults();
    send_record(4'd0, 4'hF, 16'hFFFF, 12'hFFF);
    send_record(SPECIAL_CHANNEL, MK_LINE_START, 16'd5, 12'd0);
    send_record(SPECIAL_CHANNEL, MK_LINE_END, 16'd6, 12'd0);
    send_record(SPECIAL_CHANNEL, MK_FRAME_START, 16'd10, 12'd0);
    send_record(SPECIAL_CHANNEL, MK_LINE_END, 16'd20, 12'd0);
    send_record(SPECIAL_CHANNEL, MK_LINE_START, 16'd100, 12'd0);
    send_record(4'd4, 4'd0, 16'd100, 12'd0);
    send_record(4'd5, 4'd0, 16'd355, 12'd2048);
    send_record(4'd1, 4'd0, 16'd356, 12'd1);
    send_record(4'd2, 4'd0, 16'd50, 12'd3);
    send_record(SPECIAL_CHANNEL, MK_UNUSED, 16'd400, 12'd0);
    send_record(SPECIAL_CHANNEL, MK_OVERFLOW, 16'd0, 12'd0);
    send_record(4'd3, 4'd0, 16'd0, 12'd7);
    send_record(SPECIAL_CHANNEL, MK_LINE_END, 16'd10, 12'd0);
    send_record(4'd1, 4'd0, 16'd11, 12'd9);
    send_record(SPECIAL_CHANNEL, MK_FRAME_START, 16'd12, 12'd0);
  endtask

  // Oversized width, zero height, full pixel rate and an inverted gate.
  task automatic test_column_extremes();
    configure(13'd8191, 13'd0, 32'hFFFF_FFFF, '1, 12'd100, 12'd99);
    send_record(SPECIAL_CHANNEL, MK_FRAME_START, 16'd0, 12'd0);
    send_record(SPECIAL_CHANNEL, MK_LINE_START, 16'd0, 12'd0);
    send_record(4'd1, 4'd0, 16'd0, 12'd100);
    send_record(4'd2, 4'd0, 16'd1, 12'd99);
    send_record(4'd3, 4'd0, 16'd300, 12'd100);
    send_record(SPECIAL_CHANNEL, MK_LINE_END, 16'd301, 12'd0);
  endtask

  // Halves round up; a single-bin gate; a zero pixel rate.
  task automatic test_rounding_and_gate();
    configure(13'd16, 13'd2, 32'h0080_0000, '1, 12'd2000, 12'd2000);
    send_record(SPECIAL_CHANNEL, MK_FRAME_START, 16'd900, 12'd0);
    send_record(SPECIAL_CHANNEL, MK_LINE_START, 16'd1000, 12'd0);
    send_record(4'd1, 4'd0, 16'd1001, 12'd2000);
    send_record(4'd2, 4'd0, 16'd1003, 12'd1999);
    send_record(4'd3, 4'd0, 16'd1003, 12'd2001);
    configure(13'd16, 13'd2, 32'h0, '1, 12'd0, 12'hFFF);
    send_record(4'd4, 4'd0, 16'd60000, 12'd5);
  endtask

  // A stop time of zero stops everything at once.
  task automatic test_stop_at_zero();
    configure(13'd16, 13'd2, 32'h0100_0000, '0, 12'd0, 12'hFFF);
    send_record(SPECIAL_CHANNEL, MK_FRAME_START, 16'd10, 12'd0);
    send_record(4'd1, 4'd0, 16'd20, 12'd30);
  endtask

  // Random scans under several register settings.
  task automatic test_random_scans();
    logic [BIN_W-1:0] lo;
    configure(13'd16, 13'd4, 32'h0040_0000, '1, 12'd500, 12'd3500);
    scan_records(500, 13, 1'b1);
    configure(13'd1, 13'd1, 32'h1, '1, 12'd0, 12'hFFF);
    scan_records(300, 2, 1'b1);
    configure(13'd4096, 13'd4096, 32'h1000_0000, '1, 12'd0, 12'd0);
    scan_records(300, 50, 1'b1);
    lo = BIN_W'($urandom);
    configure(13'd5, 13'd2, $urandom >> $urandom_range(0, 31), '1, lo,
              BIN_W'($urandom_range(lo, 4095)));
    scan_records(400, 3, 1'b1);
  endtask

  // The stop time is reached partway through a scan.
  task automatic test_stop_mid_scan();
    configure(13'd32, 13'd3, 32'h0080_0000, last_t + TIME_BITS'($urandom_range(200, 800)),
              12'd100, 12'd4000);
    scan_records(250, 12, 1'b1);
  endtask

  // The receiver holds off long enough for the sorter to fill and stall.
  task automatic test_backpressure();
    configure(13'd8, 13'd2, 32'h0080_0000, '1, 12'd0, 12'hFFF);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold_cycles = 300;
    scan_records(150, 4, 1'b0);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // Receiver: a random stall before each result, and a long hold on request.
  initial begin : receiver
    int stall;
    int hold;
    out_tready <= 1'b0;
    forever begin
      if (rx_hold_cycles > 0) begin
        out_tready <= 1'b0;
        hold = rx_hold_cycles;
        rx_hold_cycles = 0;
        while (hold > 0) begin
          @(posedge clk);
          hold--;
        end
      end
      stall = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Compares each accepted result with the oldest expectation.
  always @(posedge clk) begin : result_check
    sorted_photon_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected, abs_time", out_tdata[104:57], '0);
      end else begin
        want = pending_results.pop_front();
        if (out_tuser[2:0] !== want.status)
          report_mismatch("status", out_tuser[2:0], want.status);
        if (out_tuser[3] !== want.bad)
          report_mismatch("bad_channel", out_tuser[3], want.bad);
        if (out_tdata[15:0] !== want.col)
          report_mismatch("pixel_column", out_tdata[15:0], want.col);
        if (out_tdata[28:16] !== want.row)
          report_mismatch("pixel_row", out_tdata[28:16], want.row);
        if (out_tdata[44:29] !== want.frame)
          report_mismatch("frame_index", out_tdata[44:29], want.frame);
        if (out_tdata[56:45] !== want.bin)
          report_mismatch("photon_bin", out_tdata[56:45], want.bin);
        if (out_tdata[104:57] !== want.abs_t)
          report_mismatch("abs_time", out_tdata[104:57], want.abs_t);
      end
    end
  end

  initial begin : main
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;

    // Predictor starts from the reset values.
    cfg_width    = IMAGE_WIDTH_RST;
    cfg_height   = IMAGE_HEIGHT_RST;
    cfg_rate     = PIXEL_RATE_RST;
    cfg_stop     = STOP_TIME_RST;
    cfg_gate_lo  = GATE_START_RST;
    cfg_gate_hi  = GATE_STOP_RST;
    ovf_time     = '0;
    line_start   = '0;
    last_t       = '0;
    row_cnt      = '0;
    frame_cnt    = '0;
    in_line_gap  = 1'b1;
    in_frame_gap = 1'b1;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_column_extremes();
    test_rounding_and_gate();
    test_stop_at_zero();
    test_random_scans();
    test_stop_mid_scan();
    test_backpressure();

    wait_idle();
    if (mismatch_count == 0) begin
      $display("t3_photon_pixel_sorter test passed");
    end else begin
      $display("t3_photon_pixel_sorter test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/t3pps_pkg.sv
rtl/t3pps_track.sv
rtl/t3_photon_pixel_sorter.sv
tb/tb.sv
